// File: design/ihs_pkg.sv
// Package for the image header sniffer: payload structs, format codes,
// JPEG walk encodings, signature constants and small helper functions.
// No dependencies.
package ihs_pkg;

    localparam int HS_COUNT_BITS = 32;
    localparam int HDR_DEPTH     = 26;
    localparam int HDR_IDX_BITS  = $clog2(HDR_DEPTH);

    typedef enum logic [3:0] {
        FMT_UNKNOWN = 4'd0,
        FMT_PNG     = 4'd1,
        FMT_JPEG    = 4'd2,
        FMT_GIF     = 4'd3,
        FMT_BMP     = 4'd4,
        FMT_TIFF    = 4'd5,
        FMT_EMF     = 4'd6,
        FMT_WMF     = 4'd7,
        FMT_SVG     = 4'd8
    } t_format;

    typedef enum logic [2:0] {
        PH_SEEK  = 3'd0,
        PH_MARK  = 3'd1,
        PH_LENH  = 3'd2,
        PH_LENL  = 3'd3,
        PH_SKIP  = 3'd4,
        PH_FRAME = 3'd5
    } t_walk_phase;

    typedef enum logic [1:0] {
        OUT_RUN   = 2'd0,
        OUT_NONE  = 2'd1,
        OUT_FRAME = 2'd2
    } t_walk_outcome;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_format     format;
        logic [31:0] width;
        logic [31:0] height;
        logic        has_dimensions;
    } t_out_item;

    // Signatures, first file byte in the most significant position
    localparam logic [63:0] PNG_SIG     = 64'h89504E470D0A1A0A;
    localparam logic [31:0] IHDR_SIG    = 32'h49484452;
    localparam logic [47:0] GIF87_SIG   = 48'h474946383761;
    localparam logic [47:0] GIF89_SIG   = 48'h474946383961;
    localparam logic [31:0] TIFF_LE_SIG = 32'h49492A00;
    localparam logic [31:0] TIFF_BE_SIG = 32'h4D4D002A;
    localparam logic [31:0] EMF_SIG     = 32'h01000000;
    localparam logic [31:0] WMF_SIG     = 32'hD7CDC69A;
    localparam logic [39:0] XML_SIG     = 40'h3C3F786D6C;
    localparam logic [31:0] SVG_SIG     = 32'h3C737667;

    // JPEG marker codes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_JPG    = 8'hC8;
    localparam logic [7:0] MK_DAC    = 8'hCC;

    // Start-of-frame markers: C0..CF minus DHT, JPG and DAC
    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m inside {[8'hC0:8'hCF]}) && (m != MK_DHT) && (m != MK_JPG)
               && (m != MK_DAC);
    endfunction

    function automatic logic [31:0] magnitude32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

// File: design/image_header_sniffer_core.sv
// Image header sniffer top level: byte stream in, one format/size result per file.
// Depends on ihs_pkg.
//
// Result path: the last byte of a file goes into the input register, then the header/JPEG-walk
//   update writes the result register once that register can take a new value.
// Throughput: one byte per cycle. Only a last byte can be held, and only while the
//   result register still holds an untaken result from the previous file.
// Reset (synchronous, active low): clears the byte counter, the JPEG walk state and
//   both valid flags. The 26-byte header store is not cleared; the decoder only reads
//   bytes that the current file has written.
module image_header_sniffer_core
    import ihs_pkg::*;
#(
    parameter int COUNT_BITS = HS_COUNT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // ---------------- input register ----------------
    logic     r_in_valid;
    t_in_item r_in;

    // ---------------- file state ----------------
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [7:0]            r_hdr [HDR_DEPTH];
    logic [7:0]            n_hdr [HDR_DEPTH];
    t_walk_phase           r_phase, n_phase;
    t_walk_outcome         r_outcome, n_outcome;
    logic [15:0]           r_skip, n_skip;
    logic [7:0]            r_marker, n_marker;
    logic [15:0]           r_seglen, n_seglen;
    logic [15:0]           r_fh, n_fh;
    logic [15:0]           r_fw, n_fw;

    // ---------------- result register ----------------
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic out_free;    // result register can take a new value this cycle
    logic proc_go;     // registered byte is consumed this cycle
    logic in_go;       // input transaction completes this cycle

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_go    = r_in_valid && (!r_in.last || out_free);
    assign o_in_stall = r_in_valid && !proc_go;
    assign in_go      = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- per-byte update ----------------
    logic [7:0]  b;
    logic [15:0] len_v;
    logic [15:0] skip_dec;

    always_comb begin
        b         = r_in.data_byte;
        len_v     = {r_seglen[15:8], b};
        skip_dec  = r_skip - 16'd1;

        n_count   = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_BITS'(1);

        n_hdr = r_hdr;
        if (r_count < COUNT_BITS'(HDR_DEPTH)) begin
            n_hdr[r_count[HDR_IDX_BITS-1:0]] = b;
        end

        n_phase   = r_phase;
        n_outcome = r_outcome;
        n_skip    = r_skip;
        n_marker  = r_marker;
        n_seglen  = r_seglen;
        n_fh      = r_fh;
        n_fw      = r_fw;

        // JPEG marker walk, starting at offset two
        if (r_count == COUNT_MAX) begin
            // counter saturated: a walk still running gives up
            if (r_outcome == OUT_RUN) begin
                n_outcome = OUT_NONE;
            end
        end else if (r_count >= COUNT_BITS'(2) && r_outcome == OUT_RUN) begin
            case (r_phase)
                PH_MARK: begin
                    if (b == MK_PREFIX) begin
                        // fill byte, stay
                    end else if (b == MK_SOI || b == MK_TEM || (b inside {[8'hD0:8'hD7]})) begin
                        n_phase = PH_SEEK;   // standalone marker, no length
                    end else if (b == MK_EOI || b == MK_SOS) begin
                        n_outcome = OUT_NONE;
                    end else begin
                        n_marker = b;
                        n_phase  = PH_LENH;
                    end
                end
                PH_LENH: begin
                    n_seglen = {b, 8'h00};
                    n_phase  = PH_LENL;
                end
                PH_LENL: begin
                    n_seglen = len_v;
                    if (len_v < 16'd2) begin
                        n_outcome = OUT_NONE;
                    end else if (is_frame_marker(r_marker)) begin
                        n_skip  = 16'd0;
                        n_phase = PH_FRAME;
                    end else if (len_v == 16'd2) begin
                        n_phase = PH_SEEK;
                    end else begin
                        n_skip  = len_v - 16'd2;
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        n_phase = PH_SEEK;
                    end
                end
                PH_FRAME: begin
                    // frame header: precision, height hi/lo, width hi/lo
                    case (r_skip)
                        16'd1:   n_fh = {b, 8'h00};
                        16'd2:   n_fh = {r_fh[15:8], b};
                        16'd3:   n_fw = {b, 8'h00};
                        16'd4: begin
                            n_fw      = {r_fw[15:8], b};
                            n_outcome = OUT_FRAME;
                        end
                        default: ;
                    endcase
                    n_skip = r_skip + 16'd1;
                end
                default: begin
                    n_phase = (b == MK_PREFIX) ? PH_MARK : PH_SEEK;
                end
            endcase
        end
    end

    // ---------------- end-of-file decode ----------------
    logic [31:0] w, h, hs;
    logic        sized;
    logic [COUNT_BITS-1:0] len;

    always_comb begin
        len   = n_count;
        w     = 32'd0;
        h     = 32'd0;
        hs    = {n_hdr[17], n_hdr[16], n_hdr[15], n_hdr[14]};
        sized = 1'b0;
        n_out.format = FMT_UNKNOWN;

        if (len < COUNT_BITS'(4)) begin
            n_out.format = FMT_UNKNOWN;
        end else if (len >= COUNT_BITS'(8) && {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3],
                     n_hdr[4], n_hdr[5], n_hdr[6], n_hdr[7]} == PNG_SIG) begin
            n_out.format = FMT_PNG;
            if (len >= COUNT_BITS'(24) &&
                {n_hdr[12], n_hdr[13], n_hdr[14], n_hdr[15]} == IHDR_SIG) begin
                w     = {n_hdr[16], n_hdr[17], n_hdr[18], n_hdr[19]};
                h     = {n_hdr[20], n_hdr[21], n_hdr[22], n_hdr[23]};
                sized = 1'b1;
            end
        end else if (n_hdr[0] == MK_PREFIX && n_hdr[1] == MK_SOI && n_hdr[2] == MK_PREFIX) begin
            n_out.format = FMT_JPEG;
            if (n_outcome == OUT_FRAME) begin
                w     = {16'h0000, n_fw};
                h     = {16'h0000, n_fh};
                sized = 1'b1;
            end
        end else if (len >= COUNT_BITS'(6) &&
                     ({n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3], n_hdr[4], n_hdr[5]} == GIF87_SIG ||
                      {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3], n_hdr[4], n_hdr[5]} == GIF89_SIG))
        begin
            n_out.format = FMT_GIF;
            if (len >= COUNT_BITS'(10)) begin
                w     = {16'h0000, n_hdr[7], n_hdr[6]};
                h     = {16'h0000, n_hdr[9], n_hdr[8]};
                sized = 1'b1;
            end
        end else if (n_hdr[0] == 8'h42 && n_hdr[1] == 8'h4D) begin
            n_out.format = FMT_BMP;
            // info header size must be a positive value of at least 40
            if (len >= COUNT_BITS'(26) && !hs[31] && hs >= 32'd40) begin
                w     = magnitude32({n_hdr[21], n_hdr[20], n_hdr[19], n_hdr[18]});
                h     = magnitude32({n_hdr[25], n_hdr[24], n_hdr[23], n_hdr[22]});
                sized = 1'b1;
            end
        end else if ({n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]} == TIFF_LE_SIG ||
                     {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]} == TIFF_BE_SIG) begin
            n_out.format = FMT_TIFF;
        end else if ({n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]} == EMF_SIG) begin
            n_out.format = FMT_EMF;
        end else if ({n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]} == WMF_SIG) begin
            n_out.format = FMT_WMF;
        end else if ((len >= COUNT_BITS'(5) &&
                      {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3], n_hdr[4]} == XML_SIG) ||
                     {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]} == SVG_SIG) begin
            n_out.format = FMT_SVG;
        end

        n_out.width          = w;
        n_out.height         = h;
        n_out.has_dimensions = sized && (w != 32'd0) && (h != 32'd0);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_go) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_in <= i_in;
        end
    end

    // header store: written only, never cleared
    always_ff @(posedge i_clk) begin
        if (proc_go) begin
            r_hdr <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_phase   <= PH_SEEK;
            r_outcome <= OUT_RUN;
            r_skip    <= 16'd0;
            r_marker  <= 8'd0;
            r_seglen  <= 16'd0;
            r_fh      <= 16'd0;
            r_fw      <= 16'd0;
        end else if (proc_go) begin
            if (r_in.last) begin
                // file done: next byte starts a new file
                r_count   <= '0;
                r_phase   <= PH_SEEK;
                r_outcome <= OUT_RUN;
                r_skip    <= 16'd0;
                r_marker  <= 8'd0;
                r_seglen  <= 16'd0;
                r_fh      <= 16'd0;
                r_fw      <= 16'd0;
            end else begin
                r_count   <= n_count;
                r_phase   <= n_phase;
                r_outcome <= n_outcome;
                r_skip    <= n_skip;
                r_marker  <= n_marker;
                r_seglen  <= n_seglen;
                r_fh      <= n_fh;
                r_fw      <= n_fw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && r_in.last) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // a new result only follows the consumption of a last byte
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in.last))
        else $error("result without a last byte");

    // a last byte is never consumed while an untaken result would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(proc_go && r_in.last))
        else $error("pending result overwritten");

    a_dims_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.has_dimensions) |->
            (r_out.width != 32'd0 && r_out.height != 32'd0))
        else $error("has_dimensions with a zero size");

    a_sizeless_formats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.format == FMT_UNKNOWN || r_out.format == FMT_TIFF ||
                         r_out.format == FMT_EMF || r_out.format == FMT_WMF ||
                         r_out.format == FMT_SVG)) |->
            (r_out.width == 32'd0 && r_out.height == 32'd0))
        else $error("size reported for a format without sizes");

    // a completed frame header is only reached from the frame phase
    a_frame_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outcome == OUT_FRAME) |-> (r_phase == PH_FRAME))
        else $error("frame outcome outside frame phase");
`endif

endmodule

// File: dv/image_header_sniffer_core_tb.sv
// Testbench for image_header_sniffer_core: streams whole files, one byte per transaction,
// and checks each per-file result against a local predictor held in a scoreboard class.
// Depends on ihs_pkg and the core RTL.
`timescale 1ns / 1ps

module image_header_sniffer_core_tb;
    import ihs_pkg::*;

    // Byte counter width, narrower than the package default
    localparam int CNT_BITS = 16;
    localparam logic [CNT_BITS-1:0] COUNT_SAT = {CNT_BITS{1'b1}};
    localparam int LATENCY = 1;

    // Marker ranges and the BMP signature, not in the package
    localparam logic [7:0]  MK_RST0  = 8'hD0;
    localparam logic [7:0]  MK_RST7  = 8'hD7;
    localparam logic [7:0]  MK_SOF0  = 8'hC0;
    localparam logic [7:0]  MK_SOF15 = 8'hCF;
    localparam logic [7:0]  MK_APP0  = 8'hE0;
    localparam logic [15:0] BMP_SIG  = 16'h424D;
    localparam int          MAX_REPORTS = 100;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the sniffer state byte by byte and keeps the
    // per-file results still owed by the block.
    // ------------------------------------------------------------------
    class sniff_scoreboard;
        logic [7:0]          hdr [HDR_DEPTH];
        logic [CNT_BITS-1:0] nbytes;
        t_walk_phase         phase;
        t_walk_outcome       outcome;
        logic [15:0]         skip_cnt;
        logic [7:0]          marker;
        logic [15:0]         seg_len;
        logic [15:0]         frame_h;
        logic [15:0]         frame_w;
        t_out_item           owed_q[$];
        int                  errors;
        int                  file_cnt;
        int                  sized_cnt;
        int                  bytes_seen;
        int                  fmt_cnt [9];

        function new();
            errors = 0;
            file_cnt = 0;
            sized_cnt = 0;
            bytes_seen = 0;
            foreach (fmt_cnt[i]) fmt_cnt[i] = 0;
            clear_file();
        endfunction

        function void clear_file();
            foreach (hdr[i]) hdr[i] = 8'h00;
            nbytes   = '0;
            phase    = PH_SEEK;
            outcome  = OUT_RUN;
            skip_cnt = '0;
            marker   = '0;
            seg_len  = '0;
            frame_h  = '0;
            frame_w  = '0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function logic [31:0] abs_i32(input logic [31:0] v);
            return v[31] ? 32'd0 - v : v;
        endfunction

        // JPEG marker walk: seek FF, read marker, length, skip or read frame
        function void jpeg_walk(input logic [7:0] b);
            if (outcome != OUT_RUN) return;
            case (phase)
                PH_MARK: begin
                    if (b == MK_PREFIX) begin
                        // fill byte, stay
                    end else if (b == MK_SOI || b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7)) begin
                        phase = PH_SEEK;
                    end else if (b == MK_EOI || b == MK_SOS) begin
                        outcome = OUT_NONE;
                    end else begin
                        marker = b;
                        phase = PH_LENH;
                    end
                end
                PH_LENH: begin
                    seg_len = {b, 8'h00};
                    phase = PH_LENL;
                end
                PH_LENL: begin
                    seg_len = {seg_len[15:8], b};
                    if (seg_len < 16'd2) begin
                        outcome = OUT_NONE;
                    end else if (marker >= MK_SOF0 && marker <= MK_SOF15 && marker != MK_DHT
                                 && marker != MK_JPG && marker != MK_DAC) begin
                        skip_cnt = '0;
                        phase = PH_FRAME;
                    end else if (seg_len == 16'd2) begin
                        phase = PH_SEEK;
                    end else begin
                        skip_cnt = seg_len - 16'd2;
                        phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == '0) phase = PH_SEEK;
                end
                PH_FRAME: begin
                    case (skip_cnt)
                        16'd1: frame_h = {b, 8'h00};
                        16'd2: frame_h[7:0] = b;
                        16'd3: frame_w = {b, 8'h00};
                        16'd4: begin
                            frame_w[7:0] = b;
                            outcome = OUT_FRAME;
                        end
                        default: ;
                    endcase
                    skip_cnt = skip_cnt + 16'd1;
                end
                default: phase = (b == MK_PREFIX) ? PH_MARK : PH_SEEK;
            endcase
        endfunction

        // Format decision and size fields at end of file
        function t_out_item sniff_result();
            t_out_item   r;
            logic [63:0] head;
            logic [31:0] hs;
            logic        sized;
            r = '0;
            sized = 1'b0;
            head = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]};
            if (nbytes < 4) begin
                r.format = FMT_UNKNOWN;
            end else if (nbytes >= 8 && head == PNG_SIG) begin
                r.format = FMT_PNG;
                if (nbytes >= 24 && {hdr[12], hdr[13], hdr[14], hdr[15]} == IHDR_SIG) begin
                    r.width  = {hdr[16], hdr[17], hdr[18], hdr[19]};
                    r.height = {hdr[20], hdr[21], hdr[22], hdr[23]};
                    sized = 1'b1;
                end
            end else if (hdr[0] == MK_PREFIX && hdr[1] == MK_SOI && hdr[2] == MK_PREFIX) begin
                r.format = FMT_JPEG;
                if (outcome == OUT_FRAME) begin
                    r.width  = {16'h0000, frame_w};
                    r.height = {16'h0000, frame_h};
                    sized = 1'b1;
                end
            end else if (nbytes >= 6 && (head[63:16] == GIF87_SIG || head[63:16] == GIF89_SIG)) begin
                r.format = FMT_GIF;
                if (nbytes >= 10) begin
                    r.width  = {16'h0000, hdr[7], hdr[6]};
                    r.height = {16'h0000, hdr[9], hdr[8]};
                    sized = 1'b1;
                end
            end else if ({hdr[0], hdr[1]} == BMP_SIG) begin
                r.format = FMT_BMP;
                if (nbytes >= 26) begin
                    hs = {hdr[17], hdr[16], hdr[15], hdr[14]};
                    if (!hs[31] && hs >= 32'd40) begin
                        r.width  = abs_i32({hdr[21], hdr[20], hdr[19], hdr[18]});
                        r.height = abs_i32({hdr[25], hdr[24], hdr[23], hdr[22]});
                        sized = 1'b1;
                    end
                end
            end else if (head[63:32] == TIFF_LE_SIG || head[63:32] == TIFF_BE_SIG) begin
                r.format = FMT_TIFF;
            end else if (head[63:32] == EMF_SIG) begin
                r.format = FMT_EMF;
            end else if (head[63:32] == WMF_SIG) begin
                r.format = FMT_WMF;
            end else if ((nbytes >= 5 && head[63:24] == XML_SIG) || head[63:32] == SVG_SIG) begin
                r.format = FMT_SVG;
            end
            r.has_dimensions = sized && r.width != 0 && r.height != 0;
            return r;
        endfunction

        // One accepted input transaction
        function void note_input(input t_in_item it);
            t_out_item r;
            if (nbytes < HDR_DEPTH) hdr[nbytes] = it.data_byte;
            if (nbytes == COUNT_SAT) begin
                if (outcome == OUT_RUN) outcome = OUT_NONE;
            end else if (nbytes >= 2) begin
                jpeg_walk(it.data_byte);
            end
            if (nbytes != COUNT_SAT) nbytes = nbytes + 1'b1;
            bytes_seen++;
            if (it.last) begin
                r = sniff_result();
                owed_q.push_back(r);
                file_cnt++;
                fmt_cnt[r.format]++;
                if (r.has_dimensions) sized_cnt++;
                clear_file();
            end
        endfunction

        // One accepted result transaction
        function void check_result(input t_out_item got);
            t_out_item exp_r;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) $error("result with no file pending");
                return;
            end
            exp_r = owed_q.pop_front();
            if (got.format != exp_r.format) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("format: expected %0d, got %0d", exp_r.format, got.format);
            end
            if (got.width != exp_r.width) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("width: expected 0x%08h, got 0x%08h", exp_r.width, got.width);
            end
            if (got.height != exp_r.height) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("height: expected 0x%08h, got 0x%08h", exp_r.height, got.height);
            end
            if (got.has_dimensions != exp_r.has_dimensions) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("has_dimensions: expected %0b, got %0b",
                           exp_r.has_dimensions, got.has_dimensions);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_item    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;

    always #5 i_clk = ~i_clk;

    image_header_sniffer_core #(
        .COUNT_BITS(CNT_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in       (in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(out_stall)
    );

    sniff_scoreboard sb;
    int   idle_pct    = 0;    // sender: chance per cycle of holding valid low
    int   stall_pct   = 0;    // receiver: chance per cycle of stalling
    logic hold_active = 1'b0; // long receiver hold-off in progress
    logic [7:0] file_q[$];    // bytes of the file being built

    // Receiver: random stall, forced high during a hold-off
    always @(posedge i_clk) begin
        out_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end

    // Monitors: a transaction moves at an edge with valid high and stall low.
    // Values read here are the ones present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) sb.note_input(in_item);
            if (o_out_valid && !out_stall) sb.check_result(o_out);
        end
    end

    // ------------------------------------------------------------------
    // File construction
    // ------------------------------------------------------------------
    function automatic void push_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) file_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_noise(input int n);
        repeat (n) file_q.push_back(8'($urandom));
    endfunction

    function automatic logic [31:0] rand_dim32();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_dim16();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // JPEG: SOI, a few random segments, then usually a frame header
    function automatic void build_jpeg();
        logic [7:0]  m;
        logic [15:0] len;
        push_be({MK_PREFIX, MK_SOI}, 2);
        repeat ($urandom_range(0, 4)) begin
            file_q.push_back(MK_PREFIX);
            repeat ($urandom_range(0, 1) * $urandom_range(1, 2)) file_q.push_back(MK_PREFIX);
            case ($urandom_range(19))
                0, 1: file_q.push_back(MK_RST0 + 8'($urandom_range(7)));
                2:    file_q.push_back($urandom_range(1) ? MK_TEM : MK_SOI);
                3:    file_q.push_back($urandom_range(1) ? MK_EOI : MK_SOS);
                4:    push_be({MK_APP0, 8'h00, 8'($urandom_range(1))}, 3);   // bad length
                default: begin
                    case ($urandom_range(3))
                        0: m = MK_DHT;
                        1: m = $urandom_range(1) ? MK_JPG : MK_DAC;
                        default: m = MK_APP0 + 8'($urandom_range(31));
                    endcase
                    len = 16'($urandom_range(2, 9));
                    file_q.push_back(m);
                    push_be(len, 2);
                    push_noise(len - 2);
                end
            endcase
            if ($urandom_range(5) == 0) push_noise($urandom_range(1, 3));
        end
        if ($urandom_range(7) != 0) begin
            m = MK_SOF0 + 8'($urandom_range(15));
            if (m == MK_DHT || m == MK_JPG || m == MK_DAC) m = MK_SOF0;
            file_q.push_back(MK_PREFIX);
            file_q.push_back(m);
            push_be(16'h0011, 2);
            file_q.push_back(8'h08);
            push_be(rand_dim16(), 2);
            push_be(rand_dim16(), 2);
        end
        push_noise($urandom_range(0, 5));
    endfunction

    // One random file: mostly well-formed headers with random content,
    // the rest noise, plus corrupted and truncated variants.
    function automatic void build_random_file();
        int kind;
        int n;
        logic [31:0] hs;
        file_q.delete();
        kind = $urandom_range(99);
        if (kind < 14) begin
            push_be(PNG_SIG, 8);
            push_be($urandom, 4);
            push_be(($urandom_range(7) == 0) ? $urandom : IHDR_SIG, 4);
            push_be(rand_dim32(), 4);
            push_be(rand_dim32(), 4);
            push_noise($urandom_range(0, 6));
        end else if (kind < 40) begin
            build_jpeg();
        end else if (kind < 50) begin
            push_be($urandom_range(1) ? GIF87_SIG : GIF89_SIG, 6);
            push_le(rand_dim16(), 2);
            push_le(rand_dim16(), 2);
            push_noise($urandom_range(0, 6));
        end else if (kind < 62) begin
            push_be(BMP_SIG, 2);
            push_noise(12);
            case ($urandom_range(7))
                0: hs = 32'd39;
                1: hs = $urandom | 32'h8000_0000;
                2: hs = $urandom;
                3: hs = 32'd108;
                4: hs = 32'd124;
                default: hs = 32'd40;
            endcase
            push_le(hs, 4);
            push_le(rand_dim32(), 4);
            push_le(rand_dim32(), 4);
            push_noise($urandom_range(0, 6));
        end else if (kind < 74) begin
            case ($urandom_range(6))
                0: push_be(TIFF_LE_SIG, 4);
                1: push_be(TIFF_BE_SIG, 4);
                2: push_be(EMF_SIG, 4);
                3: push_be(WMF_SIG, 4);
                4: push_be(XML_SIG, 5);
                5: push_be(SVG_SIG, 4);
                default: push_be(XML_SIG >> 8, 4);  // "<?xm" alone is not SVG
            endcase
            push_noise($urandom_range(0, 8));
        end else begin
            push_noise($urandom_range(1, 30));
        end
        // broken sequences: one corrupted byte, or a cut-short file
        if ($urandom_range(9) == 0) file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
        if ($urandom_range(4) == 0) begin
            n = $urandom_range(1, file_q.size());
            while (file_q.size() > n) void'(file_q.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{data_byte: b, last: is_last};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_file();
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic send_random_files(input int byte_budget);
        int sent;
        sent = 0;
        while (sent < byte_budget) begin
            build_random_file();
            sent += file_q.size();
            send_file();
        end
    endtask

    // Sender pause until every owed result has been checked; the extra edge
    // lets the monitor see the final transaction first.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short files, extremes and the EOI, SOS and short-length stops of the walk
        file_q = '{8'hFF};                        send_file();  // one byte
        file_q = '{MK_PREFIX, MK_SOI, MK_PREFIX}; send_file();  // three bytes
        file_q.delete(); push_be(PNG_SIG, 8); push_be(32'hD, 4); push_be(IHDR_SIG, 4);
        push_be(32'hFFFF_FFFF, 4); push_be(32'h1, 4); send_file();
        file_q.delete(); push_be(PNG_SIG, 8); push_be(32'hD, 4); push_be(IHDR_SIG, 4);
        push_be(32'h0, 4); push_be(32'h20, 4); send_file();          // zero width
        file_q.delete(); push_be(PNG_SIG, 8); push_be(32'hD, 4); push_be(IHDR_SIG, 4);
        push_be(32'h40, 4); send_file();                              // size past end
        // plain frame header
        file_q = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOF0, 8'h00, 8'h11, 8'h08,
                   8'h00, 8'h10, 8'h00, 8'h20};
        send_file();
        // fill bytes, restart, TEM, SOI, empty segment, DHT, then a max-size frame
        file_q = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_PREFIX, MK_RST7, MK_PREFIX, MK_TEM,
                   MK_PREFIX, MK_SOI, MK_PREFIX, MK_APP0, 8'h00, 8'h02, 8'h55,
                   MK_PREFIX, MK_DHT, 8'h00, 8'h03, 8'hAA, MK_PREFIX, 8'hC2, 8'h00, 8'h11,
                   8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file();
        // frame with zero height: values reported, no dimensions flag
        file_q = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOF15, 8'h00, 8'h11, 8'h08,
                   8'h00, 8'h00, 8'h01, 8'h00};
        send_file();
        file_q = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_EOI, MK_PREFIX, MK_SOF0, 8'h00, 8'h11,
                   8'h08, 8'h00, 8'h10, 8'h00, 8'h20};
        send_file();                                                  // end of image
        file_q = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOS, 8'h00, 8'h08};
        send_file();                                                  // start of scan
        file_q = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_APP0, 8'h00, 8'h01, MK_PREFIX,
                   MK_SOF0, 8'h00, 8'h11, 8'h08, 8'h00, 8'h10, 8'h00, 8'h20};
        send_file();                                                  // length below 2
        file_q = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOF0, 8'h00, 8'h11, 8'h08,
                   8'h00, 8'h10, 8'h00};
        send_file();                                                  // cut inside frame
        file_q.delete(); push_be(GIF87_SIG, 6); push_le(16'hFFFF, 2); push_le(16'h1, 2);
        send_file();
        file_q.delete(); push_be(GIF89_SIG, 6); push_le(16'h5, 2); send_file();
        file_q.delete(); push_be(BMP_SIG, 2); push_noise(12); push_le(32'd40, 4);
        push_le(32'hFFFF_FFF6, 4); push_le(32'h8000_0000, 4); send_file();
        file_q.delete(); push_be(BMP_SIG, 2); push_noise(12); push_le(32'h8000_0028, 4);
        push_le(32'd5, 4); push_le(32'd5, 4); send_file();            // negative header size
        file_q.delete(); push_be(BMP_SIG, 2); push_noise(12); push_le(32'd39, 4);
        push_le(32'd5, 4); push_le(32'd5, 4); send_file();            // header size too small
        file_q.delete(); push_be(BMP_SIG, 2); push_noise(12); push_le(32'd40, 4);
        push_le(32'd5, 4); push_le(32'd5, 3); send_file();            // one byte short
        file_q.delete(); push_be(TIFF_LE_SIG, 4); send_file();
        file_q.delete(); push_be(TIFF_BE_SIG, 4); send_file();
        file_q.delete(); push_be(EMF_SIG, 4); send_file();
        file_q.delete(); push_be(WMF_SIG, 4); send_file();
        file_q.delete(); push_be(XML_SIG, 5); send_file();
        file_q.delete(); push_be(SVG_SIG, 4); send_file();
        file_q.delete(); push_be(XML_SIG >> 8, 4); send_file();
        drain();

        // Random files in four idle/stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 78; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 78; end
                default: begin idle_pct = 27; stall_pct <= 27; end
            endcase
            send_random_files(140);
            if (ph == 0) begin
                // Receiver holds off while short files keep coming, so the
                // result register fills and the input side stalls.
                fork
                    begin
                        hold_active <= 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_active <= 1'b0;
                    end
                    begin
                        repeat (12) begin
                            file_q.delete();
                            push_noise($urandom_range(1, 6));
                            send_file();
                        end
                    end
                join
            end
            drain();
        end

        stall_pct <= 0;
        drain();
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Checked %0d files (%0d sized) over %0d bytes: directed headers, walk stops,",
                 sb.file_cnt, sb.sized_cnt, sb.bytes_seen);
        $display("  four idle/stall mixes, hold-off; formats %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 sb.fmt_cnt[0], sb.fmt_cnt[1], sb.fmt_cnt[2], sb.fmt_cnt[3], sb.fmt_cnt[4],
                 sb.fmt_cnt[5], sb.fmt_cnt[6], sb.fmt_cnt[7], sb.fmt_cnt[8]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
